// ----- rtl/scf_pkg.sv -----
// Shared types, sizes and fixed-point helpers for the small Cholesky factor core.
package scf_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int IO_W       = 32;
	localparam int WIDE       = 2 * DATA_WIDTH + 2;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int ROOT_W     = (DATA_WIDTH + FRAC_BITS) / 2;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int QUO_W      = 2 * FRAC_BITS + 1;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [WIDE-1:0]       wide_t;
	typedef logic signed [IO_W-1:0]       io_t;
	typedef logic [ROOT_W-1:0]            root_t;
	typedef logic [RAD_W-1:0]             rad_t;
	typedef logic [ROOT_W+1:0]            srem_t;
	typedef logic [ROOT_W:0]              drem_t;
	typedef logic [QUO_W-1:0]             quo_t;

	localparam wide_t MAX_W = wide_t'({(DATA_WIDTH-1){1'b1}});
	localparam wide_t MIN_W = ~MAX_W;

	// word travelling down the cell chain
	typedef struct packed {
		logic [1:0] ord;
		data_t      a10;
		data_t      a20;
		data_t      a11;
		data_t      a21;
		data_t      a22;
		data_t      l00;
		data_t      l10;
		data_t      l20;
		data_t      l11;
		data_t      l21;
		data_t      r;
		data_t      t;
		logic       f0;
		logic       f1;
		logic       f2;
	} item_t;

	function automatic data_t sat(wide_t x);
		if (x > MAX_W)
			return data_t'(MAX_W);
		if (x < MIN_W)
			return data_t'(MIN_W);
		return data_t'(x);
	endfunction

	function automatic data_t take_in(io_t v);
		return sat(wide_t'(v));
	endfunction

	// product shifted down, rounded toward minus infinity
	function automatic data_t q_mul(data_t a, data_t b);
		logic signed [PROD_W-1:0] p;
		p = PROD_W'(a) * PROD_W'(b);
		return sat(wide_t'(p >>> FRAC_BITS));
	endfunction

	function automatic data_t q_sub(data_t a, data_t b);
		return sat(wide_t'(a) - wide_t'(b));
	endfunction

	function automatic rad_t make_rad(data_t x);
		if (x > 0)
			return rad_t'({x[DATA_WIDTH-2:0], {FRAC_BITS{1'b0}}});
		return '0;
	endfunction

	function automatic data_t root_to_data(root_t r);
		return data_t'({1'b0, r});
	endfunction

	function automatic data_t sat_quo(quo_t q);
		return sat(wide_t'(q));
	endfunction

endpackage

// ----- rtl/scf_sqrt_cell.sv -----
// One restoring square-root step: one root bit per cell.
module scf_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           v_i,
	input  scf_pkg::item_t item_i,
	input  scf_pkg::rad_t  rad_i,
	input  scf_pkg::srem_t rem_i,
	input  scf_pkg::root_t root_i,
	output logic           v_o,
	output scf_pkg::item_t item_o,
	output scf_pkg::rad_t  rad_o,
	output scf_pkg::srem_t rem_o,
	output scf_pkg::root_t root_o
);
	import scf_pkg::*;

	logic  v_q;
	item_t item_q;
	rad_t  rad_q;
	srem_t rem_q;
	root_t root_q;
	srem_t rem_n;
	srem_t trial;
	logic  ge;

	always_comb begin
		rem_n = {rem_i[ROOT_W-1:0], rad_i[RAD_W-1 -: 2]};
		trial = {root_i, 2'b01};
		ge    = (rem_n >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else
			v_q <= v_i;
	end

	always_ff @(posedge clk) begin
		item_q <= item_i;
		rad_q  <= rad_i << 2;
		rem_q  <= ge ? (rem_n - trial) : rem_n;
		root_q <= {root_i[ROOT_W-2:0], ge};
	end

	assign v_o    = v_q;
	assign item_o = item_q;
	assign rad_o  = rad_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;

endmodule

// ----- rtl/scf_recip_cell.sv -----
// One restoring division step of 1.0 squared by the pivot: one quotient bit per cell.
module scf_recip_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           v_i,
	input  scf_pkg::item_t item_i,
	input  scf_pkg::root_t d_i,
	input  scf_pkg::quo_t  num_i,
	input  scf_pkg::drem_t rem_i,
	input  scf_pkg::quo_t  q_i,
	output logic           v_o,
	output scf_pkg::item_t item_o,
	output scf_pkg::root_t d_o,
	output scf_pkg::quo_t  num_o,
	output scf_pkg::drem_t rem_o,
	output scf_pkg::quo_t  q_o
);
	import scf_pkg::*;

	logic  v_q;
	item_t item_q;
	root_t d_q;
	quo_t  num_q;
	drem_t rem_q;
	quo_t  q_q;
	drem_t rem_n;
	drem_t dx;
	logic  ge;

	always_comb begin
		rem_n = {rem_i[ROOT_W-1:0], num_i[QUO_W-1]};
		dx    = {1'b0, d_i};
		ge    = (rem_n >= dx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else
			v_q <= v_i;
	end

	always_ff @(posedge clk) begin
		item_q <= item_i;
		d_q    <= d_i;
		num_q  <= num_i << 1;
		rem_q  <= ge ? (rem_n - dx) : rem_n;
		q_q    <= {q_i[QUO_W-2:0], ge};
	end

	assign v_o    = v_q;
	assign item_o = item_q;
	assign d_o    = d_q;
	assign num_o  = num_q;
	assign rem_o  = rem_q;
	assign q_o    = q_q;

endmodule

// ----- rtl/scf_sqrt_unit.sv -----
// Chain of square-root cells; root of the t field of the word, zero if t is not positive.
module scf_sqrt_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_v,
	input  scf_pkg::item_t in_item,
	output logic           out_v,
	output scf_pkg::item_t out_item,
	output scf_pkg::root_t out_root
);
	import scf_pkg::*;

	logic  v_c    [ROOT_W+1];
	item_t item_c [ROOT_W+1];
	rad_t  rad_c  [ROOT_W+1];
	srem_t rem_c  [ROOT_W+1];
	root_t root_c [ROOT_W+1];

	assign v_c[0]    = in_v;
	assign item_c[0] = in_item;
	assign rad_c[0]  = make_rad(in_item.t);
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		scf_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_i    (v_c[i]),
			.item_i (item_c[i]),
			.rad_i  (rad_c[i]),
			.rem_i  (rem_c[i]),
			.root_i (root_c[i]),
			.v_o    (v_c[i+1]),
			.item_o (item_c[i+1]),
			.rad_o  (rad_c[i+1]),
			.rem_o  (rem_c[i+1]),
			.root_o (root_c[i+1])
		);
	end

	assign out_v    = v_c[ROOT_W];
	assign out_item = item_c[ROOT_W];
	assign out_root = root_c[ROOT_W];

endmodule

// ----- rtl/scf_recip_unit.sv -----
// Chain of division cells giving floor(1.0 squared / pivot).
module scf_recip_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_v,
	input  scf_pkg::item_t in_item,
	input  scf_pkg::root_t in_d,
	output logic           out_v,
	output scf_pkg::item_t out_item,
	output scf_pkg::quo_t  out_q
);
	import scf_pkg::*;

	logic  v_c    [QUO_W+1];
	item_t item_c [QUO_W+1];
	root_t d_c    [QUO_W+1];
	quo_t  num_c  [QUO_W+1];
	drem_t rem_c  [QUO_W+1];
	quo_t  q_c    [QUO_W+1];

	assign v_c[0]    = in_v;
	assign item_c[0] = in_item;
	assign d_c[0]    = in_d;
	assign num_c[0]  = {1'b1, {(QUO_W-1){1'b0}}};
	assign rem_c[0]  = '0;
	assign q_c[0]    = '0;

	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		scf_recip_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_i    (v_c[i]),
			.item_i (item_c[i]),
			.d_i    (d_c[i]),
			.num_i  (num_c[i]),
			.rem_i  (rem_c[i]),
			.q_i    (q_c[i]),
			.v_o    (v_c[i+1]),
			.item_o (item_c[i+1]),
			.d_o    (d_c[i+1]),
			.num_o  (num_c[i+1]),
			.rem_o  (rem_c[i+1]),
			.q_o    (q_c[i+1])
		);
	end

	assign out_v    = v_c[QUO_W];
	assign out_item = item_c[QUO_W];
	assign out_q    = q_c[QUO_W];

endmodule

// ----- rtl/small_cholesky_factor_core.sv -----
// Top level of the small Cholesky factor core: three root chains, two reciprocal chains.
//
// Use: drive order and the six lower-triangle entries (signed Q16.16) and pulse
// start; the word is taken at a rising edge with start high and busy low. busy
// is high only from reset until the first clock after it, so a new matrix can
// be taken every cycle.
// Each matrix gives one result word: out_00..out_22 and status, on the result
// ports for exactly one cycle with done high. On its way the word passes
// through the three bit-per-cell square-root chains (24 cells each at Q16.16)
// and the two bit-per-cell reciprocal chains (33 cells each at Q16.16); every
// cell passes its word on each cycle.
// Entries beyond the order read zero. status high marks a pivot that was zero
// or negative; that pivot and every entry after it read zero.
// Reset clears every valid flag in the chain, so words in flight are dropped and
// done stays low until a new matrix has gone through. The receiver cannot stall
// the core: results must be taken in the cycle that done is high.
module small_cholesky_factor_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [1:0]   order,
	input  scf_pkg::io_t in_00,
	input  scf_pkg::io_t in_10,
	input  scf_pkg::io_t in_20,
	input  scf_pkg::io_t in_11,
	input  scf_pkg::io_t in_21,
	input  scf_pkg::io_t in_22,
	output logic         done,
	output scf_pkg::io_t out_00,
	output scf_pkg::io_t out_10,
	output scf_pkg::io_t out_20,
	output scf_pkg::io_t out_11,
	output scf_pkg::io_t out_21,
	output scf_pkg::io_t out_22,
	output logic         status
);
	import scf_pkg::*;

	localparam int LATENCY = 3 * ROOT_W + 2 * QUO_W + 14;

	logic  rdy_q;
	logic  take;
	data_t a00_in;

	logic  v_s1;
	item_t it_s1;
	logic  v_a, v_b, v_c, v_d, v_e;
	item_t it_a, it_a2, it_b, it_c, it_c2, it_d, it_e;
	root_t root_a, root_c, root_e;
	quo_t  q_b, q_d;
	logic  v_s2, v_s3, v_s4, v_s5;
	item_t it_s2, it_s3, it_s4, it_s5;
	logic  v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	item_t it_s6, it_s7, it_s8, it_s9, it_s10, it_s11, it_s12, it_s13;
	item_t n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7;
	item_t n_s8, n_s9, n_s10, n_s11, n_s12, n_s13;

	logic  done_q, status_q;
	io_t   o00_q, o10_q, o20_q, o11_q, o21_q, o22_q;
	logic  ok0, ok1, two, three;

	assign busy   = !rdy_q;
	assign take   = start && rdy_q;
	assign a00_in = take_in(in_00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rdy_q <= 1'b0;
		else
			rdy_q <= 1'b1;
	end

	// valid flags of the arithmetic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else begin
			v_s1  <= take;
			v_s2  <= v_b;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_d;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// t carries the radicand into each root chain
	always_comb begin
		n_s1     = '0;
		n_s1.ord = (order == 2'd0) ? 2'd1 : order;
		n_s1.a10 = take_in(in_10);
		n_s1.a20 = take_in(in_20);
		n_s1.a11 = take_in(in_11);
		n_s1.a21 = take_in(in_21);
		n_s1.a22 = take_in(in_22);
		n_s1.t   = a00_in;
		n_s1.f0  = (a00_in <= 0);

		n_s2     = it_b;
		n_s2.r   = sat_quo(q_b);

		n_s3     = it_s2;
		n_s3.l10 = q_mul(it_s2.a10, it_s2.r);
		n_s3.l20 = q_mul(it_s2.a20, it_s2.r);

		n_s4     = it_s3;
		n_s4.t   = q_mul(it_s3.l10, it_s3.l10);

		n_s5     = it_s4;
		n_s5.t   = q_sub(it_s4.a11, it_s4.t);
		n_s5.f1  = it_s4.ord[1] && (n_s5.t <= 0);

		n_s6     = it_d;
		n_s6.r   = sat_quo(q_d);

		n_s7     = it_s6;
		n_s7.t   = q_mul(it_s6.l20, it_s6.l10);

		n_s8     = it_s7;
		n_s8.t   = q_sub(it_s7.a21, it_s7.t);

		n_s9     = it_s8;
		n_s9.l21 = q_mul(it_s8.t, it_s8.r);

		n_s10    = it_s9;
		n_s10.t  = q_mul(it_s9.l20, it_s9.l20);

		n_s11    = it_s10;
		n_s11.t  = q_sub(it_s10.a22, it_s10.t);

		n_s12    = it_s11;
		n_s12.r  = q_mul(it_s11.l21, it_s11.l21);

		n_s13    = it_s12;
		n_s13.t  = q_sub(it_s12.t, it_s12.r);
		n_s13.f2 = (it_s12.ord == 2'd3) && (n_s13.t <= 0);
	end

	always_ff @(posedge clk) begin
		it_s1  <= n_s1;
		it_s2  <= n_s2;
		it_s3  <= n_s3;
		it_s4  <= n_s4;
		it_s5  <= n_s5;
		it_s6  <= n_s6;
		it_s7  <= n_s7;
		it_s8  <= n_s8;
		it_s9  <= n_s9;
		it_s10 <= n_s10;
		it_s11 <= n_s11;
		it_s12 <= n_s12;
		it_s13 <= n_s13;
	end

	scf_sqrt_unit u_sqrt0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (v_s1),
		.in_item  (it_s1),
		.out_v    (v_a),
		.out_item (it_a),
		.out_root (root_a)
	);

	always_comb begin
		it_a2     = it_a;
		it_a2.l00 = root_to_data(root_a);
	end

	scf_recip_unit u_recip0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (v_a),
		.in_item  (it_a2),
		.in_d     (root_a),
		.out_v    (v_b),
		.out_item (it_b),
		.out_q    (q_b)
	);

	scf_sqrt_unit u_sqrt1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (v_s5),
		.in_item  (it_s5),
		.out_v    (v_c),
		.out_item (it_c),
		.out_root (root_c)
	);

	always_comb begin
		it_c2     = it_c;
		it_c2.l11 = root_to_data(root_c);
	end

	scf_recip_unit u_recip1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (v_c),
		.in_item  (it_c2),
		.in_d     (root_c),
		.out_v    (v_d),
		.out_item (it_d),
		.out_q    (q_d)
	);

	scf_sqrt_unit u_sqrt2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (v_s13),
		.in_item  (it_s13),
		.out_v    (v_e),
		.out_item (it_e),
		.out_root (root_e)
	);

	// entries past a failed pivot or beyond the order read zero
	always_comb begin
		two   = it_e.ord[1];
		three = (it_e.ord == 2'd3);
		ok0   = !it_e.f0;
		ok1   = ok0 && !it_e.f1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= v_e;
	end

	always_ff @(posedge clk) begin
		o00_q    <= ok0 ? io_t'(it_e.l00) : '0;
		o10_q    <= (ok0 && two) ? io_t'(it_e.l10) : '0;
		o20_q    <= (ok0 && three) ? io_t'(it_e.l20) : '0;
		o11_q    <= (ok1 && two) ? io_t'(it_e.l11) : '0;
		o21_q    <= (ok1 && three) ? io_t'(it_e.l21) : '0;
		o22_q    <= (ok1 && three && !it_e.f2) ? io_t'(root_to_data(root_e)) : '0;
		status_q <= it_e.f0 || (ok0 && it_e.f1) || (ok1 && it_e.f2);
	end

	assign done   = done_q;
	assign out_00 = o00_q;
	assign out_10 = o10_q;
	assign out_20 = o20_q;
	assign out_11 = o11_q;
	assign out_21 = o21_q;
	assign out_22 = o22_q;
	assign status = status_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result word without a matching start");

	a_good_pivot: assert property (@(posedge clk) disable iff (!arst_n)
		done && !status |-> out_00 != 0)
		else $error("valid factor with zero leading entry");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> out_22 == 0)
		else $error("last diagonal entry not cleared on failed pivot");

endmodule
